// ----- design/ntt_pkg.sv -----
// Shared types and constants of the neighbor track table.
// Used by the cells, the divider pipeline and the top level; depends on nothing.
`timescale 1ns / 1ps

package ntt_pkg;

   // One tracked neighbor as held in a table cell.
   typedef struct packed {
      logic               valid;
      logic [31:0]        time_ms;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [15:0] speed;
   } entry_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_DISTANCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_AGE_MS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECEL_RATE     = 2'd2;

   // Register reset values.
   localparam logic [15:0] MATCH_DISTANCE_RST = 16'd80;
   localparam logic [15:0] MAX_AGE_MS_RST     = 16'd300;
   localparam logic [15:0] DECEL_RATE_RST     = 16'd1152;

   // Commands.
   localparam logic CMD_BEACON = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // Divider shape: a 40-bit dividend, a 16-bit divisor, four quotient bits per stage.
   localparam int DIV_NUM_W = 40;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_BPS   = 4;

   // Dead reckoning divides by 16000 = 128 * 125; the 128 is a shift.
   localparam logic [DIV_DEN_W-1:0] BEACON_DIVISOR = 16'd125;

endpackage

// ----- design/ntt_cell.sv -----
// One cell of the rotating entry ring of the neighbor track table.
// Depends on ntt_pkg for the entry type.
`timescale 1ns / 1ps

module ntt_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  ntt_pkg::entry_type  shift_in,
   input  logic                wr_en,
   input  ntt_pkg::entry_type  wr_data,
   output ntt_pkg::entry_type  entry_out
);
   import ntt_pkg::*;

   entry_type entry_ff;

   // A direct write wins over the shift; only the valid bit is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (wr_en) begin
         entry_ff <= wr_data;
      end else if (shift_en) begin
         entry_ff <= shift_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

// ----- design/ntt_div.sv -----
// Pipelined restoring divider with a tag carried alongside each operand pair.
// Depends on ntt_pkg for nothing but the house import; one transfer per cycle.
`timescale 1ns / 1ps

module ntt_div #(
   parameter int NW  = 40,
   parameter int DW  = 16,
   parameter int TW  = 8,
   parameter int BPS = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_vld,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_vld,
   output logic [NW-1:0] out_quo,
   output logic [TW-1:0] out_tag
);
   import ntt_pkg::*;

   localparam int STAGES = NW / BPS;

   logic          vld_ff [STAGES];
   logic [NW-1:0] num_ff [STAGES];
   logic [NW-1:0] quo_ff [STAGES];
   logic [DW-1:0] rem_ff [STAGES];
   logic [DW-1:0] den_ff [STAGES];
   logic [TW-1:0] tag_ff [STAGES];

   logic [NW-1:0] num_in [STAGES];
   logic [NW-1:0] quo_in [STAGES];
   logic [DW-1:0] rem_in [STAGES];

   // Each stage retires BPS quotient bits from the registers of the stage before.
   always_comb begin
      logic [DW:0]   r;
      logic [NW-1:0] n;
      logic [NW-1:0] q;
      logic [DW-1:0] d;
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            r = '0;
            n = in_num;
            q = '0;
            d = in_den;
         end else begin
            r = {1'b0, rem_ff[s-1]};
            n = num_ff[s-1];
            q = quo_ff[s-1];
            d = den_ff[s-1];
         end
         for (int b = 0; b < BPS; b++) begin
            r = {r[DW-1:0], n[NW-1]};
            n = {n[NW-2:0], 1'b0};
            q = {q[NW-2:0], 1'b0};
            if (r >= {1'b0, d}) begin
               r = r - {1'b0, d};
               q[0] = 1'b1;
            end
         end
         num_in[s] = n;
         quo_in[s] = q;
         rem_in[s] = r[DW-1:0];
      end
   end

   // Stage registers; only the valid bits are control state.
   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         num_ff[s] <= num_in[s];
         quo_ff[s] <= quo_in[s];
         rem_ff[s] <= rem_in[s];
         if (s == 0) begin
            den_ff[s] <= in_den;
            tag_ff[s] <= in_tag;
         end else begin
            den_ff[s] <= den_ff[s-1];
            tag_ff[s] <= tag_ff[s-1];
         end
      end
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            vld_ff[s] <= (s == 0) ? in_vld : vld_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   assign out_vld = vld_ff[STAGES-1];
   assign out_quo = quo_ff[STAGES-1];
   assign out_tag = tag_ff[STAGES-1];

endmodule

// ----- design/neighbor_track_table.sv -----
// Top level of the neighbor track table: entry ring, arithmetic pipeline, sequencer.
// Depends on ntt_pkg, ntt_cell and ntt_div.
//
//   channel   ports                         transfer
//   request   start, busy, req_*            start high while busy is low
//   result    rsp_valid, rsp_*              rsp_valid high for one cycle
//   config    csr_write_en, csr_index/data  csr_write_en high, no wait
//
// A step scans the ring one entry per cycle as it rotates past the arithmetic
// pipeline, then drains that pipeline, whose depth is set by the ten-stage divider.
// Reset is synchronous; it empties the table and loads the register defaults.
// The result cannot be stalled; busy drops in the cycle the result is shown.
`timescale 1ns / 1ps

module neighbor_track_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_cmd,
   input  logic [31:0]        req_time_ms,
   input  logic signed [31:0] req_sender_x,
   input  logic signed [31:0] req_sender_y,
   input  logic signed [15:0] req_sender_speed,
   input  logic signed [31:0] req_own_x,
   input  logic signed [31:0] req_own_y,
   input  logic signed [15:0] req_own_speed,
   output logic               rsp_valid,
   output logic [3:0]         rsp_slot_index,
   output logic               rsp_new_entry,
   output logic               rsp_table_full,
   output logic               rsp_obstacle_found,
   output logic signed [15:0] rsp_target_speed,
   output logic [4:0]         rsp_live_count,
   input  logic               csr_write_en,
   input  logic [ntt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]        csr_data
);
   import ntt_pkg::*;

   localparam int IW    = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Sideband that travels with each item through the pipeline.
   typedef struct packed {
      logic               own;
      logic               last;
      logic               ent_valid;
      logic [IW-1:0]      slot;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [15:0] speed;
      logic               neg;
   } tag_type;

   localparam int TW = $bits(tag_type);

   // Sequencer and request registers.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               cmd_ff;
   logic [31:0]        time_ff;
   logic signed [31:0] sx_ff, sy_ff, ox_ff, oy_ff;
   logic signed [15:0] sspd_ff, ospd_ff;
   logic [15:0]        match_ff, age_ff, decel_ff;

   logic accept, scan_en, done_en;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= MATCH_DISTANCE_RST;
         age_ff   <= MAX_AGE_MS_RST;
         decel_ff <= DECEL_RATE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MATCH_DISTANCE: match_ff <= csr_data;
            CSR_MAX_AGE_MS:     age_ff   <= csr_data;
            CSR_DECEL_RATE:     decel_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Entry ring: cell 0 is the head, and each cell takes from the next one up.
   entry_type        cell_q [TABLE_DEPTH];
   entry_type        head, tail_in, wr_data;
   logic             shift_en, do_write;
   logic [IW-1:0]    wr_idx;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type sin;
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign sin = tail_in;
      end else begin : g_body
         assign sin = cell_q[i+1];
      end
      ntt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .shift_in  (sin),
         .wr_en     (done_en && do_write && (wr_idx == IW'(i))),
         .wr_data   (wr_data),
         .entry_out (cell_q[i])
      );
   end

   assign head = cell_q[0];

   // Feed: the first scan cycle sends the own vehicle, then one entry per cycle.
   logic        own_item, stale;
   logic [31:0] elapsed;
   tag_type     feed_tag;
   logic signed [31:0] feed_b;

   always_comb begin
      own_item = (cnt_ff == '0);
      elapsed  = time_ff - head.time_ms;
      stale    = (cmd_ff == CMD_TICK) && head.valid &&
                 ($signed(elapsed) > $signed({16'b0, age_ff}));
      tail_in       = head;
      tail_in.valid = head.valid && !stale;
      if (own_item) begin
         feed_tag.own       = 1'b1;
         feed_tag.last      = 1'b0;
         feed_tag.ent_valid = 1'b0;
         feed_tag.slot      = '0;
         feed_tag.x         = ox_ff;
         feed_tag.y         = oy_ff;
         feed_tag.speed     = ospd_ff;
      end else begin
         feed_tag.own       = 1'b0;
         feed_tag.last      = (cnt_ff == CNT_W'(TABLE_DEPTH));
         feed_tag.ent_valid = head.valid && !stale;
         feed_tag.slot      = IW'(cnt_ff - 1'b1);
         feed_tag.x         = head.x;
         feed_tag.y         = head.y;
         feed_tag.speed     = head.speed;
      end
      feed_tag.neg = 1'b0;
      feed_b = (cmd_ff == CMD_TICK) ? 32'(feed_tag.speed) : $signed(elapsed);
      shift_en = scan_en && !own_item;
   end

   // Stage 0: operand registers; stage 1: the shared multiplier.
   logic               s0_vld_ff, s1_vld_ff, s2_vld_ff;
   tag_type            s0_tag_ff, s1_tag_ff, s2_tag_ff;
   tag_type            s1_tag_c;
   logic signed [15:0] s0_a_ff;
   logic signed [31:0] s0_b_ff;
   logic signed [47:0] s1_prod_ff;
   logic [47:0]        s1_mag;
   logic [DIV_NUM_W-1:0] s2_num_ff;
   logic [DIV_DEN_W-1:0] s2_den_ff;

   // Stage 2: beacon divides |speed*elapsed| / 128 by 125, tick divides speed^2 / 32 by decel.
   assign s1_mag = s1_prod_ff[47] ? 48'(-s1_prod_ff) : 48'(s1_prod_ff);

   // The sign of a beacon product rides along with the tag.
   always_comb begin
      s1_tag_c     = s1_tag_ff;
      s1_tag_c.neg = (cmd_ff == CMD_BEACON) && s1_prod_ff[47];
   end

   always_ff @(posedge clock) begin
      s0_tag_ff  <= feed_tag;
      s0_a_ff    <= feed_tag.speed;
      s0_b_ff    <= feed_b;
      s1_tag_ff  <= s0_tag_ff;
      s1_prod_ff <= 48'(s0_a_ff) * 48'(s0_b_ff);
      s2_tag_ff  <= s1_tag_c;
      if (cmd_ff == CMD_TICK) begin
         s2_num_ff <= s1_prod_ff[44:5];
         s2_den_ff <= (decel_ff == '0) ? DIV_DEN_W'(1) : decel_ff;
      end else begin
         s2_num_ff <= s1_mag[46:7];
         s2_den_ff <= BEACON_DIVISOR;
      end
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= scan_en;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   logic                 dv_vld;
   logic [DIV_NUM_W-1:0] dv_quo;
   tag_type              dv_tag;

   ntt_div #(
      .NW  (DIV_NUM_W),
      .DW  (DIV_DEN_W),
      .TW  (TW),
      .BPS (DIV_BPS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (s2_vld_ff),
      .in_num  (s2_num_ff),
      .in_den  (s2_den_ff),
      .in_tag  (s2_tag_ff),
      .out_vld (dv_vld),
      .out_quo (dv_quo),
      .out_tag (dv_tag)
   );

   // Post stage 1: position differences for a beacon, stopping position for a tick.
   logic signed [35:0] qmag, qs, dx_c, dy_c, stop_c;
   logic               cand_c;

   always_comb begin
      qmag   = $signed({1'b0, dv_quo[34:0]});
      qs     = dv_tag.neg ? -qmag : qmag;
      dx_c   = 36'(sx_ff) - 36'(dv_tag.x) - qs;
      dy_c   = 36'(sy_ff) - 36'(dv_tag.y);
      stop_c = 36'(dv_tag.x) + 36'(dv_tag.speed / 16'sd16) +
               $signed({10'b0, dv_quo[25:0]});
      cand_c = dv_tag.ent_valid && (dv_tag.x > ox_ff) && (dv_tag.y == oy_ff);
   end

   logic               p1_vld_ff, p2_vld_ff, p3_vld_ff;
   tag_type            p1_tag_ff, p2_tag_ff, p3_tag_ff;
   logic signed [35:0] p1_dx_ff, p1_dy_ff, p1_stop_ff, p2_stop_ff, p3_stop_ff;
   logic               p1_cand_ff, p2_cand_ff, p3_cand_ff;
   logic [35:0]        magx_c, magy_c;
   logic [31:0]        p2_magx_ff, p2_magy_ff;
   logic               p2_satx_ff, p2_saty_ff, p3_sat_ff;
   logic [63:0]        p3_sqx_ff, p3_sqy_ff;

   assign magx_c = p1_dx_ff[35] ? 36'(-p1_dx_ff) : 36'(p1_dx_ff);
   assign magy_c = p1_dy_ff[35] ? 36'(-p1_dy_ff) : 36'(p1_dy_ff);

   // Post stages 2 and 3: magnitudes with saturation, then the two squares.
   always_ff @(posedge clock) begin
      p1_tag_ff  <= dv_tag;
      p1_dx_ff   <= dx_c;
      p1_dy_ff   <= dy_c;
      p1_stop_ff <= stop_c;
      p1_cand_ff <= cand_c;
      p2_tag_ff  <= p1_tag_ff;
      p2_magx_ff <= magx_c[31:0];
      p2_magy_ff <= magy_c[31:0];
      p2_satx_ff <= |magx_c[35:32];
      p2_saty_ff <= |magy_c[35:32];
      p2_stop_ff <= p1_stop_ff;
      p2_cand_ff <= p1_cand_ff;
      p3_tag_ff  <= p2_tag_ff;
      p3_sqx_ff  <= 64'(p2_magx_ff) * 64'(p2_magx_ff);
      p3_sqy_ff  <= 64'(p2_magy_ff) * 64'(p2_magy_ff);
      p3_sat_ff  <= p2_satx_ff || p2_saty_ff;
      p3_stop_ff <= p2_stop_ff;
      p3_cand_ff <= p2_cand_ff;
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= dv_vld;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
      end
   end

   // Post stage 4: saturating distance sum.
   logic [64:0] sum_c;
   logic [63:0] d2_c;
   assign sum_c = {1'b0, p3_sqx_ff} + {1'b0, p3_sqy_ff};
   assign d2_c  = (p3_sat_ff || sum_c[64]) ? '1 : sum_c[63:0];

   // Selection, free-slot and live-count trackers.
   logic [63:0]        best_d2_ff;
   logic               hit_vld_ff, pick_vld_ff, free_vld_ff;
   logic [IW-1:0]      hit_idx_ff, pick_idx_ff, free_idx_ff;
   logic signed [35:0] best_stop_ff;
   logic signed [15:0] pick_spd_ff;
   logic [CNT_W-1:0]   scan_live_ff, live_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_vld_ff   <= 1'b0;
         pick_vld_ff  <= 1'b0;
         free_vld_ff  <= 1'b0;
         scan_live_ff <= '0;
      end else if (accept) begin
         best_d2_ff   <= 64'(32'(match_ff) * 32'(match_ff));
         hit_vld_ff   <= 1'b0;
         pick_vld_ff  <= 1'b0;
         free_vld_ff  <= 1'b0;
         scan_live_ff <= '0;
      end else begin
         if (shift_en) begin
            scan_live_ff <= scan_live_ff + CNT_W'(feed_tag.ent_valid);
            if (!head.valid && !free_vld_ff) begin
               free_vld_ff <= 1'b1;
               free_idx_ff <= feed_tag.slot;
            end
         end
         if (p3_vld_ff) begin
            if (cmd_ff == CMD_BEACON) begin
               if (p3_tag_ff.ent_valid && (d2_c < best_d2_ff)) begin
                  best_d2_ff <= d2_c;
                  hit_vld_ff <= 1'b1;
                  hit_idx_ff <= p3_tag_ff.slot;
               end
            end else if (p3_tag_ff.own) begin
               best_stop_ff <= p3_stop_ff;
            end else if (p3_cand_ff && (p3_stop_ff <= best_stop_ff)) begin
               best_stop_ff <= p3_stop_ff;
               pick_vld_ff  <= 1'b1;
               pick_idx_ff  <= p3_tag_ff.slot;
               pick_spd_ff  <= p3_tag_ff.speed;
            end
         end
      end
   end

   // Outcome of the step, applied in the done state.
   logic             fresh, full, found;
   logic [IW-1:0]    slot_sel;
   logic [CNT_W-1:0] live_next;
   logic [31:0]      slot_wide, live_wide;

   always_comb begin
      do_write  = (cmd_ff == CMD_BEACON) && (hit_vld_ff || free_vld_ff);
      wr_idx    = hit_vld_ff ? hit_idx_ff : free_idx_ff;
      fresh     = (cmd_ff == CMD_BEACON) && !hit_vld_ff && free_vld_ff;
      full      = (cmd_ff == CMD_BEACON) && !hit_vld_ff && !free_vld_ff;
      found     = (cmd_ff == CMD_TICK) && pick_vld_ff;
      wr_data.valid   = 1'b1;
      wr_data.time_ms = time_ff;
      wr_data.x       = sx_ff;
      wr_data.y       = sy_ff;
      wr_data.speed   = sspd_ff;
      if (cmd_ff == CMD_BEACON) begin
         slot_sel  = do_write ? wr_idx : '0;
         live_next = live_ff + CNT_W'(fresh);
      end else begin
         slot_sel  = found ? pick_idx_ff : '0;
         live_next = scan_live_ff;
      end
      slot_wide = 32'(slot_sel);
      live_wide = 32'(live_next);
   end

   // Request capture, scan counter, live count and result registers.
   logic               rsp_valid_ff, rsp_new_ff, rsp_full_ff, rsp_found_ff;
   logic [3:0]         rsp_slot_ff;
   logic signed [15:0] rsp_speed_ff;
   logic [4:0]         rsp_live_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         time_ff <= req_time_ms;
         sx_ff   <= req_sender_x;
         sy_ff   <= req_sender_y;
         sspd_ff <= req_sender_speed;
         ox_ff   <= req_own_x;
         oy_ff   <= req_own_y;
         ospd_ff <= req_own_speed;
      end
      if (done_en) begin
         rsp_slot_ff  <= slot_wide[3:0];
         rsp_new_ff   <= fresh;
         rsp_full_ff  <= full;
         rsp_found_ff <= found;
         rsp_speed_ff <= found ? pick_spd_ff : 16'sd0;
         rsp_live_ff  <= live_wide[4:0];
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= done_en;
         if (accept) begin
            cnt_ff <= '0;
         end else if (scan_en) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (done_en) begin
            live_ff <= live_next;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_SCAN;
         ST_SCAN:  if (cnt_ff == CNT_W'(TABLE_DEPTH)) state_in = ST_DRAIN;
         ST_DRAIN: if (p3_vld_ff && p3_tag_ff.last) state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State decodes.
   always_comb begin
      busy    = 1'b1;
      scan_en = 1'b0;
      done_en = 1'b0;
      case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_SCAN:  scan_en = 1'b1;
         ST_DRAIN: ;
         ST_DONE:  done_en = 1'b1;
         default:  busy = 1'b0;
      endcase
      accept = start && !busy;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot_index     = rsp_slot_ff;
   assign rsp_new_entry      = rsp_new_ff;
   assign rsp_table_full     = rsp_full_ff;
   assign rsp_obstacle_found = rsp_found_ff;
   assign rsp_target_speed   = rsp_speed_ff;
   assign rsp_live_count     = rsp_live_ff;

   // A result strobe follows the done state and nothing else.
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DONE))
      else $error("result strobe without a finished step");

   // Busy falls only as the result is presented.
   a_busy_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // The last entry cannot leave the pipeline while the ring is still feeding.
   a_last_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !(p3_vld_ff && p3_tag_ff.last))
      else $error("last entry left the pipeline during the scan");

   // The live count never exceeds the table depth.
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CNT_W'(TABLE_DEPTH))
      else $error("live count above table depth");

endmodule

// ----- tb/tb_neighbor_track_table.sv -----
// Self-checking testbench for the neighbor track table: command driver, result monitor and a
// behavioral predictor of the table. Depends on ntt_pkg and neighbor_track_table.
`timescale 1ns / 1ps

module tb_neighbor_track_table;
   import ntt_pkg::*;

   localparam int DEPTH = 16;
   localparam int FLEET = 20;

   typedef struct {
      logic              cmd;
      logic [31:0]       t_ms;
      logic signed [31:0] sx, sy;
      logic signed [15:0] ssp;
      logic signed [31:0] ox, oy;
      logic signed [15:0] osp;
   } beacon_tick_type;

   typedef struct {
      logic [3:0]         slot;
      logic               fresh;
      logic               full;
      logic               found;
      logic signed [15:0] tspeed;
      logic [4:0]         live;
   } track_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_cmd = CMD_BEACON;
   logic [31:0] req_time_ms = '0;
   logic signed [31:0] req_sender_x = '0, req_sender_y = '0, req_own_x = '0, req_own_y = '0;
   logic signed [15:0] req_sender_speed = '0, req_own_speed = '0;
   logic rsp_valid, rsp_new_entry, rsp_table_full, rsp_obstacle_found;
   logic [3:0] rsp_slot_index;
   logic signed [15:0] rsp_target_speed;
   logic [4:0] rsp_live_count;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MATCH_DISTANCE;
   logic [15:0] csr_data = '0;

   neighbor_track_table #(.TABLE_DEPTH(DEPTH)) uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: the table and the registers as the block should hold them.
   logic [15:0]        cfg_match = MATCH_DISTANCE_RST;
   logic [15:0]        cfg_max_age = MAX_AGE_MS_RST;
   logic [15:0]        cfg_decel = DECEL_RATE_RST;
   logic               trk_valid [DEPTH];
   logic [31:0]        trk_time [DEPTH];
   logic signed [31:0] trk_x [DEPTH];
   logic signed [31:0] trk_y [DEPTH];
   logic signed [15:0] trk_speed [DEPTH];

   beacon_tick_type  pending_cmds[$];
   track_result_type expected_results[$];
   int               error_count = 0;

   function automatic longint signed_age(logic [31:0] now, logic [31:0] then);
      int d;
      d = int'(now - then);
      return longint'(d);
   endfunction

   function automatic longint unsigned square_sat(longint v);
      longint unsigned m;
      m = (v < 0) ? $unsigned(-v) : $unsigned(v);
      if (m >= 64'h1_0000_0000) return '1;
      return m * m;
   endfunction

   function automatic longint stop_pos(longint x, longint sp);
      longint d;
      d = (cfg_decel == 0) ? 1 : longint'(cfg_decel);
      return x + sp / 16 + (sp * sp) / (32 * d);
   endfunction

   // Applies one command to the predicted table and returns the result it should give.
   function automatic track_result_type track_update(beacon_tick_type c);
      track_result_type r;
      longint unsigned best_d2, d2, sum;
      longint pred, dx, dy, best_stop, st;
      int hit, live;
      r = '{default: '0};
      hit = -1;
      live = 0;
      if (c.cmd == CMD_BEACON) begin
         best_d2 = 64'(cfg_match) * 64'(cfg_match);
         for (int i = 0; i < DEPTH; i++) begin
            if (trk_valid[i]) begin
               pred = longint'(trk_x[i]) +
                      (longint'(trk_speed[i]) * signed_age(c.t_ms, trk_time[i])) / 16000;
               dx = longint'(c.sx) - pred;
               dy = longint'(c.sy) - longint'(trk_y[i]);
               sum = square_sat(dx) + square_sat(dy);
               d2 = (sum < square_sat(dx)) ? '1 : sum;
               if (d2 < best_d2) begin
                  best_d2 = d2;
                  hit = i;
               end
            end
         end
         if (hit < 0) begin
            for (int i = DEPTH - 1; i >= 0; i--)
               if (!trk_valid[i]) hit = i;
            if (hit < 0) r.full = 1'b1;
            else r.fresh = 1'b1;
         end
         if (hit >= 0) begin
            trk_valid[hit] = 1'b1;
            trk_time[hit] = c.t_ms;
            trk_x[hit] = c.sx;
            trk_y[hit] = c.sy;
            trk_speed[hit] = c.ssp;
            r.slot = hit[3:0];
         end
      end else begin
         best_stop = stop_pos(longint'(c.ox), longint'(c.osp));
         // Stale entries go first; an entry stamped in the future never ages out.
         for (int i = 0; i < DEPTH; i++)
            if (trk_valid[i] && signed_age(c.t_ms, trk_time[i]) > longint'(cfg_max_age))
               trk_valid[i] = 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            if (trk_valid[i]) begin
               st = stop_pos(longint'(trk_x[i]), longint'(trk_speed[i]));
               if (trk_x[i] > c.ox && trk_y[i] == c.oy && st <= best_stop) begin
                  best_stop = st;
                  hit = i;
               end
            end
         end
         if (hit >= 0) begin
            r.found = 1'b1;
            r.slot = hit[3:0];
            r.tspeed = trk_speed[hit];
         end
      end
      for (int i = 0; i < DEPTH; i++)
         if (trk_valid[i]) live++;
      r.live = live[4:0];
      return r;
   endfunction

   // Driver: one command per transfer, with a random gap after each and bursts without gaps.
   beacon_tick_type cur_cmd;
   int              gap_left = 0;
   logic            burst = 1'b0;
   logic            taken;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken)
            expected_results.insert(expected_results.size(), track_update(cur_cmd));
         if (start && !taken) begin
            // Held until the block accepts the transfer.
         end else if (gap_left != 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_cmds.size() != 0) begin
            cur_cmd = pending_cmds.pop_front();
            req_cmd <= cur_cmd.cmd;
            req_time_ms <= cur_cmd.t_ms;
            req_sender_x <= cur_cmd.sx;
            req_sender_y <= cur_cmd.sy;
            req_sender_speed <= cur_cmd.ssp;
            req_own_x <= cur_cmd.ox;
            req_own_y <= cur_cmd.oy;
            req_own_speed <= cur_cmd.osp;
            start <= 1'b1;
            if ($urandom_range(0, 39) == 0) burst = !burst;
            gap_left <= burst ? 0 : $urandom_range(0, 19);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: each result strobe is compared field by field with the oldest expectation.
   track_result_type exp_r;
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("Unexpected result transfer at %0t", $realtime);
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_slot_index !== exp_r.slot || rsp_new_entry !== exp_r.fresh ||
                rsp_table_full !== exp_r.full || rsp_obstacle_found !== exp_r.found ||
                rsp_target_speed !== exp_r.tspeed || rsp_live_count !== exp_r.live) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("Mismatch at %0t:", $realtime);
                  $display("  expected slot %0d new %0b full %0b found %0b speed %0d live %0d",
                           exp_r.slot, exp_r.fresh, exp_r.full, exp_r.found,
                           exp_r.tspeed, exp_r.live);
                  $display("  got      slot %0d new %0b full %0b found %0b speed %0d live %0d",
                           rsp_slot_index, rsp_new_entry, rsp_table_full,
                           rsp_obstacle_found, rsp_target_speed, rsp_live_count);
               end
            end
         end
      end
   end

   // Wait on the falling edge until the driver is empty and every result has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
      repeat (40) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_MATCH_DISTANCE: cfg_match = val;
         CSR_MAX_AGE_MS:     cfg_max_age = val;
         CSR_DECEL_RATE:     cfg_decel = val;
         default: ;
      endcase
   endtask

   task automatic csr_done();
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic beacon_tick_type mk_beacon(logic [31:0] t, int x, int y, shortint sp);
      beacon_tick_type c;
      c = '{cmd: CMD_BEACON, t_ms: t, sx: x, sy: y, ssp: sp,
            ox: $urandom, oy: $urandom, osp: 16'($urandom)};
      return c;
   endfunction

   function automatic beacon_tick_type mk_tick(logic [31:0] t, int x, int y, shortint sp);
      beacon_tick_type c;
      c = '{cmd: CMD_TICK, t_ms: t, sx: $urandom, sy: $urandom, ssp: 16'($urandom),
            ox: x, oy: y, osp: sp};
      return c;
   endfunction

   // Fleet used by the random part: vehicles in three lanes moving at constant speed.
   int          veh_x0 [FLEET];
   int          veh_y [FLEET];
   shortint     veh_sp [FLEET];
   logic [31:0] t_base;

   task automatic random_phase(int n_cmds);
      int fleet_n, v, t_rel, x;
      beacon_tick_type c;
      fleet_n = $urandom_range(3, FLEET);
      t_base = $urandom;
      t_rel = 0;
      for (int i = 0; i < fleet_n; i++) begin
         veh_x0[i] = $urandom_range(0, 40000) - 20000;
         veh_y[i] = 48 * $urandom_range(0, 2);
         veh_sp[i] = shortint'(int'($urandom_range(0, 10000)) - 2000);
      end
      for (int k = 0; k < n_cmds; k++) begin
         case ($urandom_range(0, 19))
            0: t_rel += $urandom_range(200, 2000);
            1: t_rel -= $urandom_range(0, 100);
            default: t_rel += $urandom_range(0, 40);
         endcase
         v = $urandom_range(0, fleet_n - 1);
         x = veh_x0[v] + int'((longint'(veh_sp[v]) * longint'(t_rel)) / 16000)
             + $urandom_range(0, 40) - 20;
         case ($urandom_range(0, 9))
            0: c = '{cmd: 1'($urandom), t_ms: $urandom, sx: $urandom, sy: $urandom,
                     ssp: 16'($urandom), ox: $urandom, oy: $urandom, osp: 16'($urandom)};
            1, 2: c = mk_tick(t_base + t_rel, x - $urandom_range(0, 3000), veh_y[v],
                              shortint'($urandom_range(0, 32767)));
            default: c = mk_beacon(t_base + t_rel, x, veh_y[v], veh_sp[v]);
         endcase
         pending_cmds.insert(pending_cmds.size(), c);
      end
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         trk_valid[i] = 1'b0;
         trk_time[i] = '0;
         trk_x[i] = '0;
         trk_y[i] = '0;
         trk_speed[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset register values.
      pending_cmds.insert(pending_cmds.size(), mk_beacon(32'd0, 0, 0, 16'sd0));
      pending_cmds.insert(pending_cmds.size(), mk_beacon(32'd100, 2, 0, 16'sd0));
      pending_cmds.insert(pending_cmds.size(),
                          mk_beacon(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                    16'sh7FFF));
      pending_cmds.insert(pending_cmds.size(),
                          mk_beacon(32'd5, 32'sh8000_0000, 32'sh8000_0000, 16'sh8000));
      pending_cmds.insert(pending_cmds.size(), mk_tick(32'd100, -1000, 0, 16'sh7FFF));
      pending_cmds.insert(pending_cmds.size(), mk_tick(32'd100, -1000, 0, 16'sh8000));
      for (int i = 0; i < 13; i++)
         pending_cmds.insert(pending_cmds.size(),
                             mk_beacon(32'd120, 5000 * (i + 1), 48, 16'sd3000));
      // Table is full now: the next new neighbor is dropped.
      pending_cmds.insert(pending_cmds.size(), mk_beacon(32'd130, -90000, 96, 16'sd0));
      pending_cmds.insert(pending_cmds.size(), mk_tick(32'd200, 0, 48, 16'sd20000));
      // A beacon stamped later than the following tick; the table is still full, so it is dropped.
      pending_cmds.insert(pending_cmds.size(), mk_beacon(32'd2000, 777, 777, 16'sd100));
      pending_cmds.insert(pending_cmds.size(), mk_tick(32'd1000, 0, 777, 16'sd0));
      pending_cmds.insert(pending_cmds.size(), mk_tick(32'd5000, 0, 0, 16'sd0));
      wait_drained();

      csr_write(CSR_MATCH_DISTANCE, 16'd1);
      csr_write(CSR_MAX_AGE_MS, 16'd1);
      csr_write(CSR_DECEL_RATE, 16'd1);
      csr_write(2'd3, 16'hFFFF);
      csr_done();
      random_phase(80);
      wait_drained();

      csr_write(CSR_MATCH_DISTANCE, 16'hFFFF);
      csr_write(CSR_MAX_AGE_MS, 16'hFFFF);
      csr_write(CSR_DECEL_RATE, 16'hFFFF);
      csr_done();
      random_phase(80);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         csr_write(CSR_MATCH_DISTANCE, 16'($urandom_range(20, 400)));
         csr_write(CSR_MAX_AGE_MS, 16'($urandom_range(50, 1500)));
         csr_write(CSR_DECEL_RATE, 16'($urandom_range(1, 65535)));
         csr_done();
         random_phase(80);
         wait_drained();
      end

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2ms;
      $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/ntt_pkg.sv
design/ntt_cell.sv
design/ntt_div.sv
design/neighbor_track_table.sv
tb/tb_neighbor_track_table.sv
